FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/jse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jse_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MAX_RUNS = 6;
    localparam int RW = $clog2(MAX_RUNS + 1);

    typedef enum logic [1:0] {
        K_STRUCT = 2'd0,
        K_LIST   = 2'd1,
        K_SET    = 2'd2,
        K_MAP    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        A_STRUCT_BEGIN = 4'd0,
        A_STRUCT_END   = 4'd1,
        A_FIELD_BEGIN  = 4'd2,
        A_NAME_BYTE    = 4'd3,
        A_NAME_END     = 4'd4,
        A_FIELD_END    = 4'd5,
        A_LIST_BEGIN   = 4'd6,
        A_LIST_END     = 4'd7,
        A_SET_BEGIN    = 4'd8,
        A_SET_END      = 4'd9,
        A_MAP_BEGIN    = 4'd10,
        A_MAP_END      = 4'd11,
        A_VALUE_BEGIN  = 4'd12,
        A_VALUE_BYTE   = 4'd13,
        A_VALUE_END    = 4'd14,
        A_NOP          = 4'd15
    } t_action;

    typedef enum logic [3:0] {
        E_OK         = 4'd0,
        E_ROOT       = 4'd1,
        E_NO_FIELD   = 4'd2,
        E_TOO_MANY   = 4'd3,
        E_MISMATCH   = 4'd4,
        E_MID        = 4'd5,
        E_OUTSIDE    = 4'd6,
        E_EXPECT_VAL = 4'd7,
        E_NO_VALUE   = 4'd8,
        E_COUNT_LEFT = 4'd9,
        E_OVERFLOW   = 4'd10
    } t_err;

    localparam logic [1:0] M_RAW = 2'd0;
    localparam logic [1:0] M_TEXT = 2'd1;
    localparam logic [1:0] M_BIN = 2'd2;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] rem;
        logic        wrote;
        logic        ev;
        logic        ek;
        logic        kd;
    } t_frame;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] n;
    } t_run;

    typedef struct packed {
        t_run [MAX_RUNS-1:0] r;
        logic [RW-1:0]       cnt;
    } t_runs;

    typedef struct packed {
        t_frame f;
        t_runs  rs;
    } t_fin;

    function automatic t_runs add_run(t_runs rs, logic [7:0] ch, logic [7:0] n);
        t_runs o;
        o = rs;
        if (n != 8'd0 && rs.cnt < RW'(MAX_RUNS)) begin
            o.r[rs.cnt].ch = ch;
            o.r[rs.cnt].n = n;
            o.cnt = rs.cnt + RW'(1);
        end
        return o;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
    endfunction

    function automatic t_runs add_indent(t_runs rs, logic [DW-1:0] level, logic [3:0] step);
        t_runs o;
        logic [DW+3:0] sp;
        o = rs;
        sp = level * step;
        if (step != 4'd0) begin
            o = add_run(o, 8'h0a, 8'd1);
            o = add_run(o, 8'h20, (sp > (DW+4)'(255)) ? 8'd255 : sp[7:0]);
        end
        return o;
    endfunction

    function automatic t_runs add_escaped(t_runs rs, logic [7:0] c, logic bin);
        t_runs o;
        logic [7:0] e;
        o = rs;
        case (c)
            8'd8:  e = 8'h62;
            8'd9:  e = 8'h74;
            8'd10: e = 8'h6e;
            8'd12: e = 8'h66;
            8'd13: e = 8'h72;
            8'h22: e = 8'h22;
            8'h5c: e = 8'h5c;
            default: e = 8'd0;
        endcase
        if (e != 8'd0) begin
            o = add_run(o, 8'h5c, 8'd1);
            o = add_run(o, e, 8'd1);
        end else if (c < 8'h20 || (bin && c >= 8'h7f)) begin
            o = add_run(o, 8'h5c, 8'd1);
            o = add_run(o, 8'h75, 8'd1);
            o = add_run(o, 8'h30, 8'd2);
            o = add_run(o, hex_char(c[7:4]), 8'd1);
            o = add_run(o, hex_char(c[3:0]), 8'd1);
        end else begin
            o = add_run(o, c, 8'd1);
        end
        return o;
    endfunction

    function automatic t_fin finish(t_frame f, t_runs rs, logic [3:0] step);
        t_fin o;
        o.f = f;
        o.rs = rs;
        if (f.kind == K_STRUCT) begin
            o.f.ev = 1'b0;
        end else if (f.kind == K_MAP && !f.kd) begin
            o.rs = add_run(o.rs, 8'h2c, 8'd1);
            if (step != 4'd0) o.rs = add_run(o.rs, 8'h20, 8'd1);
            o.f.kd = 1'b1;
        end else begin
            if (f.kind == K_MAP) begin
                o.rs = add_run(o.rs, 8'h5d, 8'd1);
                o.f.ek = 1'b1;
                o.f.kd = 1'b0;
            end
            o.f.rem = f.rem - 31'd1;
            o.f.wrote = 1'b1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/jse_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface jse_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [30:0] count;
    logic [7:0]  data_byte;
    logic [1:0]  value_kind;
    modport source(output valid, action, count, data_byte, value_kind, input ready);
    modport sink(input valid, action, count, data_byte, value_kind, output ready);
endinterface

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [7:0] repeat_res;
    logic       last;
    logic [3:0] error;
    modport source(output valid, out_char, repeat_res, last, error, input ready);
    modport sink(input valid, out_char, repeat_res, last, error, output ready);
endinterface

interface jse_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/json_structure_emitter.sv
// json_structure_emitter: streaming JSON writer driven by serialization events.
// i_in carries one event per beat (action, count, data_byte, value_kind).
// o_out carries runs of characters: out_char repeated repeat_res times, last
// set on the final run of an event, error nonzero on a single error run.
// i_cfg writes the indent width (spaces per level, zero for compact output);
// write it only while the block is idle. i_cfg.ready is always high.
// The first run of an event appears in the cycle after its beat.
// Throughput: one event per cycle when each event gives one run and o_out is
// ready; an event giving more runs (up to the single run buffer) stalls i_in.
// Container frames live in a MAX_DEPTH-entry memory; the top frame and the
// one below it sit in registers, refilled by a registered memory read on pop.
// Reset clears depth, root, scalar and name state and the indent width; frame
// memory is not cleared. When o_out stalls, the run buffer holds and i_in
// stays ready only for the cycle in which the last buffered run leaves.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module json_structure_emitter (
    input  wire        i_clk,
    input  wire        i_rst_n,
    jse_in_if.sink     i_in,
    jse_out_if.source  o_out,
    jse_cfg_if.sink    i_cfg
);
    import jse_pkg::*;

    t_frame        mem [MAX_DEPTH];
    t_frame        r_mem_q;
    t_frame        r_top, r_below, n_top, bl, tb, wr_frame;
    logic          r_pend;
    logic [DW-1:0] r_depth, n_depth, d;
    logic          r_root, n_root, r_sopen, n_sopen, r_nopen, n_nopen;
    logic [1:0]    r_smode, n_smode;
    logic [3:0]    r_step;
    t_runs         rs, rs_b, r_buf;
    t_fin          fin;
    t_err          err, cb, r_err;
    logic [RW-1:0] r_idx, r_left;
    logic          push, pop, accept, out_take;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] d_less3;
    t_action       act;

    assign i_cfg.ready = 1'b1;
    assign out_take = o_out.valid && o_out.ready;
    assign i_in.ready = (r_left == RW'(0)) || (r_left == RW'(1) && o_out.ready);
    assign accept = i_in.valid && i_in.ready;
    assign o_out.valid = (r_left != RW'(0));
    assign o_out.out_char = r_buf.r[r_idx].ch;
    assign o_out.repeat_res = r_buf.r[r_idx].n;
    assign o_out.last = (r_left == RW'(1));
    assign o_out.error = r_err;

    assign d = r_depth;
    assign bl = r_pend ? r_mem_q : r_below;
    assign act = t_action'(i_in.action);
    assign wr_addr = AW'(d - DW'(1));
    assign d_less3 = d - DW'(3);
    assign rd_addr = d_less3[AW-1:0];

    always_comb begin
        if (d == DW'(0)) cb = r_root ? E_ROOT : E_OK;
        else if (r_top.kind == K_STRUCT) cb = r_top.ev ? E_OK : E_NO_FIELD;
        else cb = (r_top.rem == 31'd0) ? E_TOO_MANY : E_OK;

        rs_b = '0;
        tb = r_top;
        if (d != DW'(0) && r_top.kind != K_STRUCT) begin
            if (r_top.kind == K_MAP) begin
                if (r_top.ek) begin
                    if (r_top.wrote) rs_b = add_run(rs_b, 8'h2c, 8'd1);
                    rs_b = add_indent(rs_b, d, r_step);
                    rs_b = add_run(rs_b, 8'h5b, 8'd1);
                    tb.ek = 1'b0;
                    tb.kd = 1'b0;
                end
            end else begin
                if (r_top.wrote) rs_b = add_run(rs_b, 8'h2c, 8'd1);
                rs_b = add_indent(rs_b, d, r_step);
            end
        end
    end

    always_comb begin
        rs = '0;
        err = E_OK;
        n_top = r_top;
        push = 1'b0;
        pop = 1'b0;
        n_depth = d;
        n_root = r_root;
        n_smode = r_smode;
        n_sopen = r_sopen;
        n_nopen = r_nopen;
        wr_frame = tb;
        fin = '0;
        if (act == A_NOP) begin
            err = E_OK;
        end else if (r_sopen ? (act != A_VALUE_BYTE && act != A_VALUE_END)
                   : r_nopen ? (act != A_NAME_BYTE && act != A_NAME_END)
                   : (act == A_NAME_BYTE || act == A_NAME_END ||
                      act == A_VALUE_BYTE || act == A_VALUE_END)) begin
            err = E_MID;
        end else begin
            case (act)
                A_STRUCT_BEGIN, A_LIST_BEGIN, A_SET_BEGIN, A_MAP_BEGIN: begin
                    if (cb != E_OK) err = cb;
                    else if (d >= DW'(MAX_DEPTH)) err = E_OVERFLOW;
                    else begin
                        rs = add_run(rs_b, (act == A_STRUCT_BEGIN) ? 8'h7b : 8'h5b, 8'd1);
                        push = 1'b1;
                        n_top.kind = (act == A_STRUCT_BEGIN) ? K_STRUCT :
                                     (act == A_LIST_BEGIN) ? K_LIST :
                                     (act == A_SET_BEGIN) ? K_SET : K_MAP;
                        n_top.rem = (act == A_STRUCT_BEGIN) ? 31'd0 : i_in.count;
                        n_top.wrote = 1'b0;
                        n_top.ev = 1'b0;
                        n_top.ek = 1'b1;
                        n_top.kd = 1'b0;
                        n_depth = d + DW'(1);
                    end
                end
                A_STRUCT_END, A_LIST_END, A_SET_END, A_MAP_END: begin
                    if (d == DW'(0)) err = E_MISMATCH;
                    else if (r_top.kind != ((act == A_STRUCT_END) ? K_STRUCT :
                                            (act == A_LIST_END) ? K_LIST :
                                            (act == A_SET_END) ? K_SET : K_MAP))
                        err = E_MISMATCH;
                    else if (r_top.kind == K_STRUCT && r_top.ev) err = E_MID;
                    else if (r_top.kind == K_MAP && !r_top.ek) err = E_MID;
                    else if (r_top.kind != K_STRUCT && r_top.rem != 31'd0)
                        err = E_COUNT_LEFT;
                    else begin
                        pop = 1'b1;
                        n_depth = d - DW'(1);
                        if (r_top.wrote) rs = add_indent(rs, d - DW'(1), r_step);
                        rs = add_run(rs, (act == A_STRUCT_END) ? 8'h7d : 8'h5d, 8'd1);
                        if (d == DW'(1)) n_root = 1'b1;
                        else begin
                            fin = finish(bl, rs, r_step);
                            n_top = fin.f;
                            rs = fin.rs;
                        end
                    end
                end
                A_FIELD_BEGIN: begin
                    if (d == DW'(0) || r_top.kind != K_STRUCT) err = E_OUTSIDE;
                    else if (r_top.ev) err = E_EXPECT_VAL;
                    else begin
                        if (r_top.wrote) rs = add_run(rs, 8'h2c, 8'd1);
                        rs = add_indent(rs, d, r_step);
                        rs = add_run(rs, 8'h22, 8'd1);
                        n_top.ev = 1'b1;
                        n_top.wrote = 1'b1;
                        n_nopen = 1'b1;
                    end
                end
                A_NAME_BYTE: rs = add_escaped(rs, i_in.data_byte, 1'b0);
                A_NAME_END: begin
                    rs = add_run(rs, 8'h22, 8'd1);
                    rs = add_run(rs, 8'h3a, 8'd1);
                    if (r_step != 4'd0) rs = add_run(rs, 8'h20, 8'd1);
                    n_nopen = 1'b0;
                end
                A_FIELD_END: begin
                    if (d == DW'(0) || r_top.kind != K_STRUCT) err = E_OUTSIDE;
                    else if (r_top.ev) err = E_NO_VALUE;
                end
                A_VALUE_BEGIN: begin
                    if (cb != E_OK) err = cb;
                    else begin
                        rs = rs_b;
                        n_top = tb;
                        n_smode = (i_in.value_kind == 2'd3) ? M_BIN : i_in.value_kind;
                        if (n_smode != M_RAW) rs = add_run(rs, 8'h22, 8'd1);
                        n_sopen = 1'b1;
                    end
                end
                A_VALUE_BYTE: begin
                    if (r_smode == M_RAW) rs = add_run(rs, i_in.data_byte, 8'd1);
                    else rs = add_escaped(rs, i_in.data_byte, r_smode == M_BIN);
                end
                A_VALUE_END: begin
                    if (r_smode != M_RAW) rs = add_run(rs, 8'h22, 8'd1);
                    n_sopen = 1'b0;
                    if (d == DW'(0)) n_root = 1'b1;
                    else begin
                        fin = finish(r_top, rs, r_step);
                        n_top = fin.f;
                        rs = fin.rs;
                    end
                end
                default: err = E_OK;
            endcase
        end
        if (err != E_OK || rs.cnt == RW'(0)) begin
            rs = '0;
            rs.cnt = RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= mem[rd_addr];
        if (accept && err == E_OK && push && d != DW'(0)) begin
            mem[wr_addr] <= wr_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_root <= 1'b0;
            r_smode <= M_RAW;
            r_sopen <= 1'b0;
            r_nopen <= 1'b0;
            r_step <= 4'd0;
            r_pend <= 1'b0;
            r_left <= '0;
            r_idx <= '0;
        end else begin
            if (i_cfg.valid) r_step <= i_cfg.data;
            r_below <= (accept && err == E_OK && push) ? wr_frame : bl;
            r_pend <= accept && err == E_OK && pop;
            if (accept) begin
                r_buf <= rs;
                r_err <= err;
                r_idx <= '0;
                r_left <= rs.cnt;
                if (err == E_OK) begin
                    r_top <= n_top;
                    r_depth <= n_depth;
                    r_root <= n_root;
                    r_smode <= n_smode;
                    r_sopen <= n_sopen;
                    r_nopen <= n_nopen;
                end
            end else if (out_take) begin
                r_idx <= r_idx + RW'(1);
                r_left <= r_left - RW'(1);
            end
        end
    end

    `JSE_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DW'(MAX_DEPTH), "depth out of range")
    `JSE_ASSERT_IMP(a_buf_bound, i_clk, i_rst_n, 1'b1, r_left <= RW'(MAX_RUNS) && r_idx < RW'(MAX_RUNS), "run buffer out of range")
    `JSE_ASSERT_IMP(a_no_drop, i_clk, i_rst_n, accept && r_left != RW'(0), r_left == RW'(1) && out_take, "beat accepted over pending runs")
    `JSE_ASSERT_NXT(a_refill, i_clk, i_rst_n, r_pend && !accept, !r_pend, "below frame refill stuck")

endmodule
`default_nettype wire
